// ===== rtl/lsmcg_pkg.sv =====
// ----------------------------------------------------------------------------
// lsmcg_pkg
// Shared types, constants and lookup tables of the LED strip mode and color
// generator.
// ----------------------------------------------------------------------------
package lsmcg_pkg;

  // Light modes in press order
  localparam logic [1:0] MODE_RAINBOW = 2'd0;
  localparam logic [1:0] MODE_STROBE  = 2'd1;
  localparam logic [1:0] MODE_WHITE   = 2'd2;
  localparam logic [1:0] MODE_STROBEW = 2'd3;

  localparam int unsigned KnobW     = 10;
  localparam int unsigned ColorW    = 24;
  localparam int unsigned HoldW     = 10;
  localparam int unsigned HueIdxW   = 6;
  localparam int unsigned PctW      = 6;
  localparam int unsigned SpeedIdxW = 4;
  localparam int unsigned SpeedStep = 1023 / 9;
  localparam int unsigned SpeedSteps = 9;

  localparam logic [ColorW-1:0] ColorWhite = 24'hffffff;
  localparam logic [ColorW-1:0] ColorBlack = 24'h000000;

  // One classified item, as queued between front and back
  typedef struct packed {
    logic [1:0]           mode;
    logic [HueIdxW-1:0]   hue_idx;
    logic [PctW-1:0]      pct;
    logic [SpeedIdxW-1:0] speed_idx;
  } lsmcg_entry_t;

  // Hue wheel, 0xRRGGBB
  function automatic logic [ColorW-1:0] hue_rgb(input logic [HueIdxW-1:0] idx);
    logic [ColorW-1:0] c;
    case (idx)
      6'd0:  c = 24'hff0000;  6'd1:  c = 24'hff1a00;  6'd2:  c = 24'hff3300;
      6'd3:  c = 24'hff4d00;  6'd4:  c = 24'hff6600;  6'd5:  c = 24'hff8000;
      6'd6:  c = 24'hff9900;  6'd7:  c = 24'hffb300;  6'd8:  c = 24'hffcc00;
      6'd9:  c = 24'hffe600;  6'd10: c = 24'hffff00;  6'd11: c = 24'he6ff00;
      6'd12: c = 24'hccff00;  6'd13: c = 24'hb3ff00;  6'd14: c = 24'h99ff00;
      6'd15: c = 24'h80ff00;  6'd16: c = 24'h66ff00;  6'd17: c = 24'h4dff00;
      6'd18: c = 24'h33ff00;  6'd19: c = 24'h1aff00;  6'd20: c = 24'h00ff00;
      6'd21: c = 24'h00ff1a;  6'd22: c = 24'h00ff33;  6'd23: c = 24'h00ff4d;
      6'd24: c = 24'h00ff66;  6'd25: c = 24'h00ff80;  6'd26: c = 24'h00ff99;
      6'd27: c = 24'h00ffb3;  6'd28: c = 24'h00ffcc;  6'd29: c = 24'h00ffe6;
      6'd30: c = 24'h00ffff;  6'd31: c = 24'h00e6ff;  6'd32: c = 24'h00ccff;
      6'd33: c = 24'h00b3ff;  6'd34: c = 24'h0099ff;  6'd35: c = 24'h0080ff;
      6'd36: c = 24'h0066ff;  6'd37: c = 24'h004dff;  6'd38: c = 24'h0033ff;
      6'd39: c = 24'h001aff;  6'd40: c = 24'h0000ff;  6'd41: c = 24'h1a00ff;
      6'd42: c = 24'h3300ff;  6'd43: c = 24'h4d00ff;  6'd44: c = 24'h6600ff;
      6'd45: c = 24'h8000ff;  6'd46: c = 24'h9900ff;  6'd47: c = 24'hb300ff;
      6'd48: c = 24'hcc00ff;  6'd49: c = 24'he600ff;  6'd50: c = 24'hff00ff;
      6'd51: c = 24'hff00e6;  6'd52: c = 24'hff00cc;  6'd53: c = 24'hff00b3;
      6'd54: c = 24'hff0099;  6'd55: c = 24'hff0080;  6'd56: c = 24'hff0066;
      6'd57: c = 24'hff004d;  6'd58: c = 24'hff0033;  6'd59: c = 24'hff001a;
      default: c = 24'hff001a;
    endcase
    return c;
  endfunction

  // Strobe hold time in ms per speed step
  function automatic logic [HoldW-1:0] hold_time(input logic [SpeedIdxW-1:0] idx);
    logic [HoldW-1:0] h;
    case (idx)
      4'd0:    h = 10'd1000;
      4'd1:    h = 10'd600;
      4'd2:    h = 10'd500;
      4'd3:    h = 10'd400;
      4'd4:    h = 10'd300;
      4'd5:    h = 10'd200;
      4'd6:    h = 10'd100;
      4'd7:    h = 10'd50;
      4'd8:    h = 10'd10;
      default: h = 10'd11;
    endcase
    return h;
  endfunction

endpackage

// ===== rtl/lsmcg_if.sv =====
// ----------------------------------------------------------------------------
// lsmcg_if
// Valid/ready channels of the generator: control loop passes in, frames out.
// ----------------------------------------------------------------------------
interface lsmcg_in_if;
  logic                          valid;
  logic                          ready;
  logic                          button_pressed;
  logic [lsmcg_pkg::KnobW-1:0]   hue_knob;
  logic [lsmcg_pkg::KnobW-1:0]   level_knob;

  modport source (output valid, button_pressed, hue_knob, level_knob, input ready);
  modport sink   (input valid, button_pressed, hue_knob, level_knob, output ready);
endinterface

interface lsmcg_out_if;
  logic                          valid;
  logic                          ready;
  logic [lsmcg_pkg::ColorW-1:0]  color_grb;
  logic [lsmcg_pkg::HoldW-1:0]   hold_ms;
  logic                          last;

  modport source (output valid, color_grb, hold_ms, last, input ready);
  modport sink   (input valid, color_grb, hold_ms, last, output ready);
endinterface

// ===== rtl/lsmcg_front.sv =====
// ----------------------------------------------------------------------------
// lsmcg_front
// Accepts loop passes, advances the light mode and classifies the knobs into
// hue index, brightness percent and strobe speed step.
// ----------------------------------------------------------------------------
module lsmcg_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  lsmcg_in_if.sink                in_i,
  input  logic                    full_i,
  output logic                    push_o,
  output lsmcg_pkg::lsmcg_entry_t entry_o
);
  import lsmcg_pkg::*;

  logic [1:0]           mode_q, mode_d;
  logic [15:0]          hue_prod, lvl_prod;
  logic [HueIdxW-1:0]   hue_idx;
  logic [PctW-1:0]      pct;
  logic [KnobW-1:0]     speed_knob;
  logic [SpeedIdxW-1:0] speed_idx;

  // x / 1023 for x below 65472 (quotient fits six bits): quotient of x / 1024 plus at most one
  function automatic logic [5:0] div1023(input logic [15:0] x);
    logic [5:0]  q0;
    logic [15:0] q0x, r;
    q0  = x[15:10];
    q0x = {q0, 10'b0} - {10'b0, q0};
    r   = x - q0x;
    return (r >= 16'd1023) ? q0 + 6'd1 : q0;
  endfunction

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  // Mode advance on a press
  assign mode_d = in_i.button_pressed ? mode_q + 2'd1 : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RAINBOW;
    end else if (push_o) begin
      mode_q <= mode_d;
    end
  end

  // Hue index and brightness percent
  assign hue_prod = 16'(in_i.hue_knob) * 16'd59;
  assign lvl_prod = 16'(in_i.level_knob) * 16'd50;
  assign hue_idx  = div1023(hue_prod);
  assign pct      = div1023(lvl_prod);

  // Speed step: strobe reads the level knob, strobe white the hue knob
  assign speed_knob = (mode_d == MODE_STROBEW) ? in_i.hue_knob : in_i.level_knob;

  always_comb begin
    speed_idx = '0;
    for (int k = 1; k <= SpeedSteps; k++) begin
      if (speed_knob >= KnobW'(k * SpeedStep)) begin
        speed_idx = speed_idx + SpeedIdxW'(1);
      end
    end
  end

  assign entry_o.mode      = mode_d;
  assign entry_o.hue_idx   = hue_idx;
  assign entry_o.pct       = pct;
  assign entry_o.speed_idx = speed_idx;

endmodule

// ===== rtl/lsmcg_queue.sv =====
// ----------------------------------------------------------------------------
// lsmcg_queue
// Small register FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module lsmcg_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  lsmcg_pkg::lsmcg_entry_t entry_i,
  output logic                    full_o,
  input  logic                    pop_i,
  output logic                    avail_o,
  output lsmcg_pkg::lsmcg_entry_t entry_o
);
  import lsmcg_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  lsmcg_entry_t    mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign avail_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && avail_o;
  assign entry_o = mem_q[rptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/lsmcg_back.sv =====
// ----------------------------------------------------------------------------
// lsmcg_back
// Sequencer that scales the frame color (not in strobe mode), orders it GRB and
// sends one frame, or a color frame and a black frame for the strobe modes.
// ----------------------------------------------------------------------------
module lsmcg_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    avail_i,
  input  lsmcg_pkg::lsmcg_entry_t entry_i,
  output logic                    pop_o,
  lsmcg_out_if.source             out_o
);
  import lsmcg_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_RECIP = 3'd2;
  localparam logic [2:0] ST_FIX   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]        state_q, state_d;
  lsmcg_entry_t      ent_q;
  logic [ColorW-1:0] base;
  logic [13:0]       prod_q [3];
  logic [7:0]        quo_q  [3];
  logic [7:0]        scaled [3];
  logic [ColorW-1:0] scaled_rgb, frame;
  logic              second_q;
  logic [ColorW-1:0] color_q;
  logic [HoldW-1:0]  hold_q;
  logic              last_q;

  function automatic logic [ColorW-1:0] to_grb(input logic [ColorW-1:0] w);
    return {w[15:8], w[23:16], w[7:0]};
  endfunction

  assign pop_o = (state_q == ST_IDLE) && avail_i;

  // Unscaled color of this item, 0xRRGGBB
  assign base = (ent_q.mode == MODE_RAINBOW || ent_q.mode == MODE_STROBE)
              ? hue_rgb(ent_q.hue_idx) : ColorWhite;

  // Per channel: product, quotient estimate by 655/65536, one correction
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [13:0] q100, r;
      q100 = {quo_q[c], 6'b0} + {1'b0, quo_q[c], 5'b0} + {4'b0, quo_q[c], 2'b0};
      r    = prod_q[c] - q100;
      scaled[c] = (r >= 14'd100) ? quo_q[c] + 8'd1 : quo_q[c];
    end
  end

  assign scaled_rgb = {scaled[2], scaled[1], scaled[0]};

  always_comb begin
    case (ent_q.mode)
      MODE_RAINBOW: frame = to_grb(scaled_rgb);
      MODE_STROBE:  frame = to_grb(base);
      default:      frame = scaled_rgb;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (avail_i) state_d = ST_MUL;
      ST_MUL:   state_d = ST_RECIP;
      ST_RECIP: state_d = ST_FIX;
      ST_FIX:   state_d = ST_OUT;
      ST_OUT:   if (out_o.ready && !second_q) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      second_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_FIX) begin
        second_q <= ent_q.mode[0];
      end else if (state_q == ST_OUT && out_o.ready) begin
        second_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q <= entry_i;
    end
    if (state_q == ST_MUL) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[c] <= 14'(base[8*c +: 8]) * 14'(ent_q.pct);
      end
    end
    if (state_q == ST_RECIP) begin
      for (int c = 0; c < 3; c++) begin
        quo_q[c] <= 8'((24'(prod_q[c]) * 24'd655) >> 16);
      end
    end
    if (state_q == ST_FIX) begin
      color_q <= frame;
      hold_q  <= ent_q.mode[0] ? hold_time(ent_q.speed_idx) : '0;
      last_q  <= !ent_q.mode[0];
    end else if (state_q == ST_OUT && out_o.ready && second_q) begin
      color_q <= ColorBlack;
      last_q  <= 1'b1;
    end
  end

  assign out_o.valid     = (state_q == ST_OUT);
  assign out_o.color_grb = color_q;
  assign out_o.hold_ms   = hold_q;
  assign out_o.last      = last_q;

endmodule

// ===== rtl/led_strip_mode_color_generator_core.sv =====
// ----------------------------------------------------------------------------
// led_strip_mode_color_generator_core
// LED strip mode and color generator: mode cycle on button presses, frame
// color and strobe hold time from two knob samples.
// ----------------------------------------------------------------------------
// Each accepted pass goes through the queue to the back-end sequencer, whose
// MUL, RECIP and FIX steps precede its first frame; strobe modes add a black
// frame. The back takes the next pass only once its last frame is taken.
// The front accepts passes into a QueueDepth-entry queue while the back works.
// Reset: light mode returns to rainbow, queue and sequencer empty.
module led_strip_mode_color_generator_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lsmcg_in_if.sink    in_i,
  lsmcg_out_if.source out_o
);
  import lsmcg_pkg::*;

  logic         push, full, pop, avail;
  lsmcg_entry_t push_entry, pop_entry;

  lsmcg_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  lsmcg_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .entry_o (pop_entry)
  );

  lsmcg_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (avail),
    .entry_i (pop_entry),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== sim/tb_led_strip_mode_color_generator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_strip_mode_color_generator_core
// Self-checking bench for the LED strip mode and color generator. Control
// loop passes go in over the input channel. A behavioral predictor follows
// the mode cycle and works out every frame (color, hold time, last flag).
// Each frame that comes out is compared with the oldest predicted one.
// Directed passes cover the knob extremes, the speed table edges, every mode,
// the wrap and a held button. Random passes then run under several mixes of
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_led_strip_mode_color_generator_core;
  import lsmcg_pkg::*;

  localparam int unsigned ClkHalf     = 10;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned MaxReports  = 10;

  // Hue wheel, 0xRRGGBB, one entry per hue step
  localparam logic [23:0] HueWheel [60] = '{
    24'hff0000, 24'hff1a00, 24'hff3300, 24'hff4d00, 24'hff6600,
    24'hff8000, 24'hff9900, 24'hffb300, 24'hffcc00, 24'hffe600,
    24'hffff00, 24'he6ff00, 24'hccff00, 24'hb3ff00, 24'h99ff00,
    24'h80ff00, 24'h66ff00, 24'h4dff00, 24'h33ff00, 24'h1aff00,
    24'h00ff00, 24'h00ff1a, 24'h00ff33, 24'h00ff4d, 24'h00ff66,
    24'h00ff80, 24'h00ff99, 24'h00ffb3, 24'h00ffcc, 24'h00ffe6,
    24'h00ffff, 24'h00e6ff, 24'h00ccff, 24'h00b3ff, 24'h0099ff,
    24'h0080ff, 24'h0066ff, 24'h004dff, 24'h0033ff, 24'h001aff,
    24'h0000ff, 24'h1a00ff, 24'h3300ff, 24'h4d00ff, 24'h6600ff,
    24'h8000ff, 24'h9900ff, 24'hb300ff, 24'hcc00ff, 24'he600ff,
    24'hff00ff, 24'hff00e6, 24'hff00cc, 24'hff00b3, 24'hff0099,
    24'hff0080, 24'hff0066, 24'hff004d, 24'hff0033, 24'hff001a
  };

  // Strobe hold in ms per speed step
  localparam logic [9:0] StrobeHold [10] = '{
    10'd1000, 10'd600, 10'd500, 10'd400, 10'd300,
    10'd200, 10'd100, 10'd50, 10'd10, 10'd11
  };

  typedef struct {
    logic [ColorW-1:0] color_grb;
    logic [HoldW-1:0]  hold_ms;
    logic              last;
  } frame_t;

  logic clk_i;
  logic rst_ni;

  lsmcg_in_if  in_if ();
  lsmcg_out_if out_if ();

  led_strip_mode_color_generator_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predictor state and expected frames
  logic [1:0] light_mode;
  frame_t     expected_frames[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatches = 0;
  int unsigned passes_sent;
  int unsigned presses_sent;
  int unsigned frames_checked = 0;
  int unsigned strobe_passes;

  // Clock
  initial clk_i = 1'b0;
  always #(ClkHalf) clk_i = ~clk_i;

  // Run limit
  initial begin
    #(10_000_000);
    $display("timeout: %0d frames still expected", expected_frames.size());
    $display("simulation failed");
    $finish;
  end

  // Scale each byte of a 24-bit word by pct percent, truncating
  function automatic logic [23:0] scale_color(logic [23:0] w, int unsigned pct);
    int unsigned g2, g1, g0;
    g2 = int'(w[23:16]) * pct / 100;
    g1 = int'(w[15:8]) * pct / 100;
    g0 = int'(w[7:0]) * pct / 100;
    return {g2[7:0], g1[7:0], g0[7:0]};
  endfunction

  // 0xRRGGBB to 0xGGRRBB
  function automatic logic [23:0] rgb_to_grb(logic [23:0] w);
    return {w[15:8], w[23:16], w[7:0]};
  endfunction

  function automatic logic [9:0] strobe_hold_for(logic [KnobW-1:0] knob);
    int unsigned i;
    i = int'(knob) / SpeedStep;
    if (i > SpeedSteps) i = SpeedSteps;
    return StrobeHold[i];
  endfunction

  // Advance the mode on a press and queue the frames of this pass
  task automatic predict_frames(logic press, logic [KnobW-1:0] hue,
                                logic [KnobW-1:0] level);
    int unsigned pct;
    int unsigned idx;
    frame_t      f;
    logic [9:0]  hold;
    pct = int'(level) * 50 / 1023;
    idx = int'(hue) * 59 / 1023;
    if (idx > 59) idx = 59;
    if (press) light_mode = light_mode + 2'd1;
    case (light_mode)
      MODE_RAINBOW: begin
        f.color_grb = rgb_to_grb(scale_color(HueWheel[idx], pct));
        f.hold_ms   = '0;
        f.last      = 1'b1;
        expected_frames.push_back(f);
      end
      MODE_STROBE: begin
        hold = strobe_hold_for(level);
        f.color_grb = rgb_to_grb(HueWheel[idx]);
        f.hold_ms   = hold;
        f.last      = 1'b0;
        expected_frames.push_back(f);
        f.color_grb = ColorBlack;
        f.last      = 1'b1;
        expected_frames.push_back(f);
        strobe_passes++;
      end
      MODE_WHITE: begin
        f.color_grb = scale_color(ColorWhite, pct);
        f.hold_ms   = '0;
        f.last      = 1'b1;
        expected_frames.push_back(f);
      end
      default: begin
        hold = strobe_hold_for(hue);
        f.color_grb = scale_color(ColorWhite, pct);
        f.hold_ms   = hold;
        f.last      = 1'b0;
        expected_frames.push_back(f);
        f.color_grb = ColorBlack;
        f.last      = 1'b1;
        expected_frames.push_back(f);
        strobe_passes++;
      end
    endcase
  endtask

  // Compare one transferred frame with the oldest expectation
  task automatic check_frame();
    frame_t exp_f;
    if (expected_frames.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0t: unexpected frame color=%06h hold=%0d last=%0b", $realtime,
                 out_if.color_grb, out_if.hold_ms, out_if.last);
    end else begin
      exp_f = expected_frames.pop_front();
      frames_checked++;
      if (out_if.color_grb !== exp_f.color_grb || out_if.hold_ms !== exp_f.hold_ms ||
          out_if.last !== exp_f.last) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: frame %0d expected color=%06h hold=%0d last=%0b, got %06h %0d %0b",
                   $realtime, frames_checked, exp_f.color_grb, exp_f.hold_ms, exp_f.last,
                   out_if.color_grb, out_if.hold_ms, out_if.last);
      end
    end
  endtask

  // Frame sink: check each transfer, then stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) check_frame();
    out_if.ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // Send one pass; valid stays high into the next pass unless a gap is taken
  task automatic send_pass(logic press, logic [KnobW-1:0] hue, logic [KnobW-1:0] level);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid          <= 1'b1;
    in_if.button_pressed <= press;
    in_if.hue_knob       <= hue;
    in_if.level_knob     <= level;
    do @(posedge clk_i); while (!in_if.ready);
    predict_frames(press, hue, level);
    passes_sent++;
    if (press) presses_sent++;
  endtask

  // Hold off until every expected frame has come, then let the block settle
  task automatic drain_frames();
    in_if.valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Knob sample biased toward the ends and the speed step edges
  function automatic logic [KnobW-1:0] pick_knob();
    int unsigned k;
    case ($urandom_range(7))
      0: k = 0;
      1: k = 1023;
      2: k = SpeedStep * $urandom_range(SpeedSteps + 1) + $urandom_range(2) - 1;
      default: k = $urandom_range(1023);
    endcase
    return k[KnobW-1:0];
  endfunction

  // Knob extremes and speed table edges across all four modes
  task automatic test_directed_extremes();
    send_pass(1'b0, 10'd0, 10'd0);        // rainbow, dark
    send_pass(1'b0, 10'd1023, 10'd1023);  // last hue, full brightness
    send_pass(1'b0, 10'd511, 10'd512);
    send_pass(1'b1, 10'd1023, 10'd0);     // strobe, slowest
    send_pass(1'b0, 10'd0, 10'd1023);     // past the last speed step
    send_pass(1'b0, 10'd17, 10'd904);
    send_pass(1'b0, 10'd700, 10'd112);
    send_pass(1'b0, 10'd701, 10'd113);
    send_pass(1'b1, 10'd0, 10'd1023);     // white, full
    send_pass(1'b0, 10'd1023, 10'd0);     // white, dark
    send_pass(1'b1, 10'd1023, 10'd1023);  // strobe white, past the last speed step
    send_pass(1'b0, 10'd0, 10'd500);
    send_pass(1'b0, 10'd1016, 10'd20);
    send_pass(1'b1, 10'd341, 10'd682);    // wrap back to rainbow
    drain_frames();
  endtask

  // Button held over several passes steps through every mode
  task automatic test_held_button();
    repeat (5) send_pass(1'b1, 10'h2aa, 10'h155);
    send_pass(1'b0, 10'h155, 10'h2aa);
    repeat (3) send_pass(1'b1, 10'h3ff, 10'h3ff);
    drain_frames();
  endtask

  // Random passes under one idling mix; presses come alone or in held runs
  task automatic test_random_passes(int unsigned n, int unsigned s_pct, int unsigned r_pct);
    int unsigned sent;
    int unsigned run;
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(15) == 0) begin
        run = $urandom_range(6, 1);
        repeat (run) send_pass(1'b1, pick_knob(), pick_knob());
        sent += run;
      end else begin
        send_pass($urandom_range(4) == 0, pick_knob(), pick_knob());
        sent++;
      end
    end
    drain_frames();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    rst_ni               = 1'b0;
    in_if.valid          = 1'b0;
    in_if.button_pressed = 1'b0;
    in_if.hue_knob       = '0;
    in_if.level_knob     = '0;
    light_mode           = MODE_RAINBOW;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    passes_sent          = 0;
    presses_sent         = 0;
    strobe_passes        = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_extremes();
    test_held_button();
    test_random_passes(175, 0, 0);
    test_random_passes(175, 48, 0);
    test_random_passes(175, 0, 48);
    test_random_passes(175, 10, 10);

    $display("covered %0d passes (%0d presses, %0d strobe passes), %0d frames checked",
             passes_sent, presses_sent, strobe_passes, frames_checked);
    $display("idling mixes: none, sender gaps, receiver stalls, both; %0d mismatches, %0d missing",
             mismatches, expected_frames.size());
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
